// ----- hw/rtl/b32h_pkg.sv -----
// Shared types, constants and the character mapping of the base32hex stream encoder.
// Used by every module of the block; depends on nothing.
package b32h_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;

   localparam logic [6:0] ASCII_ZERO       = 7'h30;  // '0'
   localparam logic [6:0] ASCII_ALPHA_BASE = 7'h57;  // 'a' - 10
   localparam logic [6:0] PAD_CHAR         = 7'h3d;  // '='
   localparam logic [4:0] DIGIT_LIMIT      = 5'd10;

   // Position of the next byte within its five-byte group.
   typedef enum logic [4:0] {
      PH_B0 = 5'b00001,
      PH_B1 = 5'b00010,
      PH_B2 = 5'b00100,
      PH_B3 = 5'b01000,
      PH_B4 = 5'b10000
   } phase_type;

   // One accepted byte as the back end sees it: up to three 5-bit values
   // (data characters, then the flush character) followed by padding.
   typedef struct packed {
      logic [2:0][4:0] quints;
      logic [1:0]      num_quints;
      logic [2:0]      num_pads;
      logic            last;
   } job_type;

   function automatic logic [6:0] to_ascii(input logic [4:0] v);
      logic [6:0] ch;
      if (v < DIGIT_LIMIT) begin
         ch = ASCII_ZERO + {2'b00, v};
      end else begin
         ch = ASCII_ALPHA_BASE + {2'b00, v};
      end
      return ch;
   endfunction

endpackage

// ----- hw/rtl/b32h_if.sv -----
// Valid/ready channel interfaces for the byte input and the character output.
// Stand alone; no package needed.
interface b32h_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface b32h_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] out_char;
   logic       out_last;

   modport source (output valid, output out_char, output out_last, input ready);
   modport sink   (input valid, input out_char, input out_last, output ready);
endinterface

// ----- hw/rtl/b32h_front.sv -----
// Front end: accepts bytes, tracks the group phase and leftover bits, and
// turns each byte into a character job. Depends on b32h_pkg and b32h_req_if.
module b32h_front import b32h_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   b32h_req_if.sink          req_if,
   output logic              push_valid,
   input  logic              push_ready,
   output job_type           push_job
);

   phase_type  phase_ff, phase_in;
   logic [3:0] left_ff, left_in;
   logic       accept;

   logic [4:0] first_q, second_q, flush_q;
   logic [3:0] next_left;
   logic       two_data;
   logic [2:0] pads;
   logic       group_end;
   phase_type  next_phase;

   assign req_if.ready = push_ready;
   assign push_valid   = req_if.valid;
   assign accept       = req_if.valid && push_ready;

   always_comb begin
      first_q    = '0;
      second_q   = '0;
      flush_q    = '0;
      next_left  = '0;
      two_data   = 1'b0;
      pads       = '0;
      group_end  = 1'b0;
      next_phase = PH_B0;
      unique case (phase_ff)
         PH_B1: begin
            first_q    = {left_ff[2:0], req_if.in_byte[7:6]};
            second_q   = req_if.in_byte[5:1];
            next_left  = {3'b000, req_if.in_byte[0]};
            flush_q    = {req_if.in_byte[0], 4'b0000};
            two_data   = 1'b1;
            pads       = 3'd4;
            next_phase = PH_B2;
         end
         PH_B2: begin
            first_q    = {left_ff[0], req_if.in_byte[7:4]};
            next_left  = req_if.in_byte[3:0];
            flush_q    = {req_if.in_byte[3:0], 1'b0};
            pads       = 3'd3;
            next_phase = PH_B3;
         end
         PH_B3: begin
            first_q    = {left_ff[3:0], req_if.in_byte[7]};
            second_q   = req_if.in_byte[6:2];
            next_left  = {2'b00, req_if.in_byte[1:0]};
            flush_q    = {req_if.in_byte[1:0], 3'b000};
            two_data   = 1'b1;
            pads       = 3'd1;
            next_phase = PH_B4;
         end
         PH_B4: begin
            first_q    = {left_ff[1:0], req_if.in_byte[7:5]};
            second_q   = req_if.in_byte[4:0];
            two_data   = 1'b1;
            group_end  = 1'b1;
            next_phase = PH_B0;
         end
         default: begin
            // Start of a group; an unknown phase is treated the same way.
            first_q    = req_if.in_byte[7:3];
            next_left  = {1'b0, req_if.in_byte[2:0]};
            flush_q    = {req_if.in_byte[2:0], 2'b00};
            pads       = 3'd6;
            next_phase = PH_B1;
         end
      endcase
   end

   always_comb begin
      push_job.quints[0] = first_q;
      push_job.quints[1] = two_data ? second_q : flush_q;
      push_job.quints[2] = flush_q;
      push_job.last      = req_if.in_last;
      if (req_if.in_last && !group_end) begin
         push_job.num_quints = two_data ? 2'd3 : 2'd2;
         push_job.num_pads   = pads;
      end else begin
         push_job.num_quints = two_data ? 2'd2 : 2'd1;
         push_job.num_pads   = '0;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      left_in  = left_ff;
      if (accept) begin
         if (req_if.in_last) begin
            phase_in = PH_B0;
            left_in  = '0;
         end else begin
            phase_in = next_phase;
            left_in  = next_left;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_B0;
         left_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

   a_last_restarts_group: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.in_last) |=> (phase_ff == PH_B0 && left_ff == '0))
      else $error("group not restarted after last byte");

   a_group_start_clean: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_B0) |-> (left_ff == '0))
      else $error("leftover bits present at start of group");

endmodule

// ----- hw/rtl/b32h_queue.sv -----
// Short job queue between the front and back ends, held in registers.
// Depends on b32h_pkg for the job type.
module b32h_queue import b32h_pkg::*; #(
   parameter int unsigned Depth = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt  = CntW'(Depth);

   job_type             mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != FullCnt);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("queue count exceeds its depth");

endmodule

// ----- hw/rtl/b32h_back.sv -----
// Back end: walks each job one character per cycle into the output register,
// holding while a sent character waits. Depends on b32h_pkg and b32h_rsp_if.
module b32h_back import b32h_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      job_valid,
   output logic      job_pop,
   input  job_type   job,
   b32h_rsp_if.source rsp_if
);

   logic [2:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;

   logic [3:0] total;
   logic       final_char;
   logic       emit;
   logic [4:0] cur_quint;

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.out_char = char_ff;
   assign rsp_if.out_last = last_ff;

   assign total      = {2'b00, job.num_quints} + {1'b0, job.num_pads};
   assign final_char = (({1'b0, idx_ff} + 4'd1) == total);
   assign emit       = job_valid && (!rsp_valid_ff || rsp_if.ready);
   assign job_pop    = emit && final_char;

   always_comb begin
      case (idx_ff)
         3'd0:    cur_quint = job.quints[0];
         3'd1:    cur_quint = job.quints[1];
         default: cur_quint = job.quints[2];
      endcase
   end

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      char_in      = char_ff;
      last_in      = last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         last_in      = job.last && final_char;
         if ({1'b0, idx_ff} < {1'b0, job.num_quints}) begin
            char_in = to_ascii(cur_quint);
         end else begin
            char_in = PAD_CHAR;
         end
         idx_in = final_char ? '0 : idx_ff + 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_job_held_mid_walk: assert property (@(posedge clock) disable iff (reset)
      (idx_ff != '0) |-> job_valid)
      else $error("job left the queue before all its characters were sent");

   a_walk_restarts: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> (idx_ff == '0))
      else $error("character index not cleared after a job");

   a_last_marks_job_end: assert property (@(posedge clock) disable iff (reset)
      (emit && job.last && final_char) |=> (rsp_valid_ff && last_ff))
      else $error("final character of a message not flagged");

endmodule

// ----- hw/rtl/base32hex_stream_encoder.sv -----
// Base32hex stream encoder (lowercase alphabet 0-9, a-v). A byte is accepted in
// any cycle in which the job queue has room, so bytes can arrive back to back;
// each byte becomes a job of one or two characters, and a byte flagged last that
// leaves a group open also brings the flush character and '=' padding to close
// the eight-character group, for up to eight characters in all; the final one is
// flagged by out_last. The back end's single output register sends one character
// per cycle unless the output is stalled; about 1.6 characters per byte sustained.
// A byte's job is pushed into the job queue and its first character is then
// registered in the output register. QueueDepth sets how many jobs may wait
// between the byte side and the character side.
module base32hex_stream_encoder import b32h_pkg::*; #(
   parameter int unsigned QueueDepth = QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   b32h_req_if.sink    req_if,
   b32h_rsp_if.source  rsp_if
);

   logic    push_valid, push_ready;
   job_type push_job;
   logic    pop_valid, pop_ready;
   job_type pop_job;

   b32h_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   b32h_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   b32h_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_pop   (pop_ready),
      .job       (pop_job),
      .rsp_if    (rsp_if)
   );

endmodule

// ----- test/tb_base32hex_stream_encoder.sv -----
// Self-checking testbench for base32hex_stream_encoder: random and directed
// messages against a cycle-free character predictor. Needs b32h_pkg, b32h_if.
module tb_base32hex_stream_encoder;
   import b32h_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int MAX_WAIT      = 17;
   localparam int RANDOM_BYTES  = 160;
   localparam int REPORT_LIMIT  = 10;

   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         drain;  // hold this item back until every character is out
   } msg_byte_type;

   typedef struct packed {
      logic [6:0] ch;
      logic       last;
   } enc_char_type;

   logic clock;
   logic reset;

   b32h_req_if req_ch ();
   b32h_rsp_if rsp_ch ();

   base32hex_stream_encoder u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   msg_byte_type byte_q [$];
   enc_char_type char_q [$];
   phase_type    enc_phase;
   logic [3:0]   enc_left;

   int bytes_total;
   int bytes_accepted;
   int messages_total;
   int chars_seen;
   int mismatch_count;
   int cycle_count;
   int send_gap;
   int recv_gap;
   bit send_burst;
   bit recv_burst;

   always #5 clock = ~clock;

   function automatic logic [6:0] quint_char(input logic [4:0] v);
      if (v < 5'd10) begin
         return ASCII_ZERO + {2'b00, v};
      end
      return ASCII_ALPHA_BASE + {2'b00, v};
   endfunction

   task automatic push_char(input logic [6:0] ch);
      enc_char_type c;
      c.ch   = ch;
      c.last = 1'b0;
      char_q.push_back(c);
   endtask

   // Appends the characters one accepted byte produces and advances the group state.
   task automatic encode_byte(input logic [7:0] b, input logic last);
      logic [4:0] flush;
      int         used;
      phase_type  next;
      flush = '0;
      used  = 8;
      case (enc_phase)
         PH_B1: begin
            push_char(quint_char({enc_left[2:0], b[7:6]}));
            push_char(quint_char(b[5:1]));
            enc_left = {3'b000, b[0]};
            flush    = {b[0], 4'b0000};
            used     = 4;
            next     = PH_B2;
         end
         PH_B2: begin
            push_char(quint_char({enc_left[0], b[7:4]}));
            enc_left = b[3:0];
            flush    = {b[3:0], 1'b0};
            used     = 5;
            next     = PH_B3;
         end
         PH_B3: begin
            push_char(quint_char({enc_left[3:0], b[7]}));
            push_char(quint_char(b[6:2]));
            enc_left = {2'b00, b[1:0]};
            flush    = {b[1:0], 3'b000};
            used     = 7;
            next     = PH_B4;
         end
         PH_B4: begin
            push_char(quint_char({enc_left[1:0], b[7:5]}));
            push_char(quint_char(b[4:0]));
            enc_left = '0;
            next     = PH_B0;
         end
         default: begin
            push_char(quint_char(b[7:3]));
            enc_left = {1'b0, b[2:0]};
            flush    = {b[2:0], 2'b00};
            used     = 2;
            next     = PH_B1;
         end
      endcase
      enc_phase = next;
      if (last) begin
         // A last byte that closes a group needs no flush character or padding.
         if (enc_phase != PH_B0) begin
            push_char(quint_char(flush));
            for (int i = used; i < 8; i++) begin
               push_char(PAD_CHAR);
            end
         end
         char_q[char_q.size() - 1].last = 1'b1;
         enc_phase = PH_B0;
         enc_left  = '0;
      end
   endtask

   task automatic queue_byte(input logic [7:0] data, input logic last, input bit drain);
      msg_byte_type m;
      m.data  = data;
      m.last  = last;
      m.drain = drain;
      byte_q.push_back(m);
      bytes_total++;
      if (last) begin
         messages_total++;
      end
   endtask

   task automatic note_mismatch(input enc_char_type exp_c, input enc_char_type act_c);
      if (mismatch_count < REPORT_LIMIT) begin
         $display("Mismatch at character %0d: expected char 0x%02h last %0b,",
                  chars_seen, exp_c.ch, exp_c.last);
         $display("   got char 0x%02h last %0b", act_c.ch, act_c.last);
      end
      mismatch_count++;
   endtask

   // Sender side.
   always @(posedge clock) begin
      msg_byte_type cur;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            encode_byte(req_ch.in_byte, req_ch.in_last);
            bytes_accepted++;
            if ($urandom_range(0, 15) == 0) begin
               send_burst = !send_burst;
            end
            send_gap = send_burst ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (req_ch.valid && !req_ch.ready) begin
            // Item still waiting to be taken; hold it.
         end else if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (byte_q.size() > 0 && (!byte_q[0].drain || char_q.size() == 0)) begin
            cur = byte_q.pop_front();
            req_ch.valid   <= 1'b1;
            req_ch.in_byte <= cur.data;
            req_ch.in_last <= cur.last;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver side: checks every accepted character in order.
   always @(posedge clock) begin
      enc_char_type exp_c;
      enc_char_type act_c;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            act_c.ch   = rsp_ch.out_char;
            act_c.last = rsp_ch.out_last;
            if (char_q.size() == 0) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("Unexpected character 0x%02h last %0b with nothing pending",
                           act_c.ch, act_c.last);
               end
               mismatch_count++;
            end else begin
               exp_c = char_q.pop_front();
               if (exp_c.ch !== act_c.ch || exp_c.last !== act_c.last) begin
                  note_mismatch(exp_c, act_c);
               end
            end
            chars_seen++;
            if ($urandom_range(0, 15) == 0) begin
               recv_burst = !recv_burst;
            end
            recv_gap = recv_burst ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d of %0d bytes taken",
                  cycle_count, bytes_accepted, bytes_total);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      logic [7:0] dir_bytes [22];
      int         dir_lens [7];
      int         pos;
      int         len;
      int         random_bytes;
      bit         drain;
      logic [7:0] b;

      clock          = 1'b0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.in_byte = '0;
      req_ch.in_last = 1'b0;
      rsp_ch.ready   = 1'b0;
      enc_phase      = PH_B0;
      enc_left       = '0;
      bytes_total    = 0;
      bytes_accepted = 0;
      messages_total = 0;
      chars_seen     = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      send_gap       = 0;
      recv_gap       = 0;
      send_burst     = 1'($urandom_range(0, 1));
      recv_burst     = 1'($urandom_range(0, 1));

      // Messages ending at every group position, the last one closing a full group
      // and one running past it.
      dir_bytes = '{8'h00,
                    8'hff,
                    8'h00, 8'hff,
                    8'hff, 8'h00, 8'hff,
                    8'haa, 8'h55, 8'hf0, 8'h0f,
                    8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                    8'h12, 8'h34, 8'h56, 8'h78, 8'h9a, 8'hbc};
      dir_lens  = '{1, 1, 2, 3, 4, 5, 6};
      pos = 0;
      foreach (dir_lens[m]) begin
         for (int i = 0; i < dir_lens[m]; i++) begin
            queue_byte(dir_bytes[pos], i == dir_lens[m] - 1, m == 3 && i == 0);
            pos++;
         end
      end

      random_bytes = 0;
      while (random_bytes < RANDOM_BYTES) begin
         len   = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
         drain = ($urandom_range(0, 9) == 0);
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 7))
               0:       b = 8'h00;
               1:       b = 8'hff;
               default: b = 8'($urandom_range(0, 255));
            endcase
            queue_byte(b, i == len - 1, drain && i == 0);
         end
         random_bytes += len;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (bytes_accepted < bytes_total) @(posedge clock);
      while (char_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes in %0d messages and checked %0d characters in %0d cycles.",
               bytes_total, messages_total, chars_seen, cycle_count);
      $display("Mismatches: %0d, characters still pending: %0d",
               mismatch_count, char_q.size());
      if (mismatch_count == 0 && char_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
